// ===== rtl/core/kdt_pkg.sv =====
// Shared types for the keyed delay timer table: poll and result items,
// status codes and the layout of one slot memory entry.
// Depends on nothing; every RTL file of the block imports it.
package kdt_pkg;

    typedef enum logic [2:0] {
        ST_BYPASS    = 3'd0,
        ST_STARTED   = 3'd1,
        ST_RESTARTED = 3'd2,
        ST_WAITING   = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0]        delay_key;
        logic [31:0]        delay_ms;
        logic signed [15:0] task_label;
        logic [31:0]        now_ms;
        logic               in_interrupt;
    } poll_t;

    typedef struct packed {
        logic    done_res;
        status_t status;
    } result_t;

    // One slot of the table memory.
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] label;
        logic [31:0] target;
    } slot_t;

endpackage

// ===== rtl/core/keyed_delay_timer_table.sv =====
// Top level of the keyed delay timer table: slot memory, valid bits,
// scan sequencer and the result register.
// Depends on kdt_pkg for the item types and status codes.

// The block keeps up to TABLE_ENTRIES one-shot delays, each keyed by a 32-bit id.
// Every poll item returns exactly one result item. A poll from interrupt context
// or with a zero delay is answered as a bypass without touching the table; it
// goes from idle straight to the reply state. Any other poll scans the slot
// memory one entry per cycle through its single read port, so the scan sets the
// rate. The scan stops at the first matching slot; a poll that misses (new key
// or full table) reads every slot. The update state then acts on the outcome
// before the reply state loads the result into the output register.
// One poll is in work at a time; the next poll is accepted as soon as the
// result has moved into the output register, even while that result is
// still stalled downstream. Key, label and target of each slot live in a
// synchronous memory with registered read data; the valid bits are flip-flops
// cleared by reset, so no clearing pass is needed after reset. A new key takes
// the lowest free slot, and an expired poll frees its slot.
module keyed_delay_timer_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              poll_valid,
    output logic              poll_stall,
    input  kdt_pkg::poll_t    poll,
    output logic              result_valid,
    input  logic              result_stall,
    output kdt_pkg::result_t  result
);
    import kdt_pkg::*;

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_REPLY  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Slot memory and its registered read port.
    slot_t mem [TABLE_ENTRIES];
    slot_t rd_data_reg;
    logic  mem_we;
    logic [IdxW-1:0] mem_waddr;
    slot_t mem_wdata;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // The poll in work.
    poll_t       item_reg;
    logic [31:0] target_reg;

    // Scan sequencer: reads are issued at scan_idx and compared in the next cycle.
    logic [IdxW-1:0] scan_idx_reg;
    logic            issue_done_reg;
    logic [IdxW-1:0] cmp_idx_reg;
    logic            cmp_en_reg;

    logic            hit_reg;
    logic [IdxW-1:0] hit_idx_reg;
    logic [15:0]     hit_label_reg;
    logic [31:0]     hit_target_reg;
    logic            free_found_reg;
    logic [IdxW-1:0] free_idx_reg;

    result_t res_reg, res_next;
    logic    out_valid_reg;
    result_t out_reg;

    logic accept;
    logic bypass;
    logic cmp_hit;
    logic cmp_last;
    logic cmp_free;
    logic out_free;

    assign poll_stall   = (state_reg != S_IDLE);
    assign accept       = poll_valid && !poll_stall;
    assign bypass       = poll.in_interrupt || (poll.delay_ms == 32'd0);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    assign cmp_hit  = cmp_en_reg && valid_reg[cmp_idx_reg]
                      && (rd_data_reg.key == item_reg.delay_key);
    assign cmp_last = cmp_en_reg && (cmp_idx_reg == LastIdx);
    assign cmp_free = cmp_en_reg && !valid_reg[cmp_idx_reg] && !free_found_reg;

    // Memory: one write port, one read port, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    // Decision for the update cycle, plus the state sequence.
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = hit_reg ? hit_idx_reg : free_idx_reg;
        mem_wdata.key    = item_reg.delay_key;
        mem_wdata.label  = item_reg.task_label;
        mem_wdata.target = target_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bypass ? S_REPLY : S_SCAN;
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_BYPASS;
                end
            end
            S_SCAN:
            begin
                if (cmp_hit || cmp_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_REPLY;
                res_next.done_res = 1'b0;
                if (!hit_reg)
                begin
                    if (free_found_reg)
                    begin
                        mem_we = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        res_next.status = ST_STARTED;
                    end
                    else
                    begin
                        res_next.status = ST_FULL;
                    end
                end
                else if (hit_label_reg != item_reg.task_label)
                begin
                    mem_we = 1'b1;
                    res_next.status = ST_RESTARTED;
                end
                else if (item_reg.now_ms >= hit_target_reg)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_EXPIRED;
                end
                else
                begin
                    res_next.status = ST_WAITING;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cmp_en_reg     <= 1'b0;
            issue_done_reg <= 1'b0;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;

            if (state_reg == S_REPLY && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                scan_idx_reg   <= '0;
                issue_done_reg <= 1'b0;
                cmp_en_reg     <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                // Stop issuing reads once the last slot has been read.
                cmp_en_reg <= !issue_done_reg && !(cmp_hit || cmp_last);
                if (scan_idx_reg == LastIdx)
                begin
                    issue_done_reg <= 1'b1;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + IdxW'(1);
                end
                if (cmp_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            else
            begin
                cmp_en_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        cmp_idx_reg <= scan_idx_reg;
        if (accept)
        begin
            item_reg   <= poll;
            target_reg <= poll.now_ms + poll.delay_ms;
        end
        if (state_reg == S_SCAN && cmp_hit)
        begin
            hit_idx_reg    <= cmp_idx_reg;
            hit_label_reg  <= rd_data_reg.label;
            hit_target_reg <= rd_data_reg.target;
        end
        if (state_reg == S_SCAN && cmp_free)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (state_reg == S_REPLY && out_free)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

// ===== tb/tb_keyed_delay_timer_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keyed_delay_timer_table: directed table, then random polls.
// Depends on kdt_pkg and keyed_delay_timer_table; needs no files or arguments.
module tb_keyed_delay_timer_table;
    import kdt_pkg::*;

    localparam int SLOTS      = 16;
    localparam int N_RANDOM   = 1950;
    localparam int IDLE_LIMIT = 2000;
    localparam int POOL_SIZE  = 32;

    // One row of the directed table. When typed is set, the expected result is
    // written into the row. Otherwise the delay table model supplies it.
    typedef struct {
        poll_t   p;
        bit      typed;
        result_t want;
    } poll_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    poll_valid   = 1'b0;
    logic    poll_stall;
    poll_t   poll         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Shadow copy of the delay table, updated as each poll item is accepted.
    bit          tbl_valid  [SLOTS];
    bit [31:0]   tbl_key    [SLOTS];
    bit [15:0]   tbl_label  [SLOTS];
    bit [31:0]   tbl_target [SLOTS];

    result_t     pending_results[$];
    int          mismatches = 0;
    int          status_seen[6];
    int          polls_sent = 0;

    // Receiver stall pattern: a mode is held for a random number of cycles.
    int          stall_mode = 0;
    int          stall_left = 0;

    keyed_delay_timer_table #(
        .TABLE_ENTRIES(SLOTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll_valid  (poll_valid),
        .poll_stall  (poll_stall),
        .poll        (poll),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always #2 clk = ~clk;

    // Works out the result of one poll and updates the shadow table the way
    // the block updates its slots.
    function automatic result_t predict_poll(poll_t p);
        result_t   r;
        int        hit;
        int        free_idx;
        bit [31:0] target;
        hit      = -1;
        free_idx = -1;
        target   = p.now_ms + p.delay_ms;
        r.done_res = 1'b0;
        r.status   = ST_BYPASS;
        if (p.in_interrupt || p.delay_ms == 32'd0) begin
            r.done_res = 1'b1;
            return r;
        end
        // Lowest matching slot wins, and a new key takes the lowest free slot.
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_key[i] == p.delay_key)
                hit = i;
            if (!tbl_valid[i])
                free_idx = i;
        end
        if (hit < 0) begin
            if (free_idx < 0) begin
                r.status = ST_FULL;
            end
            else begin
                tbl_valid[free_idx]  = 1'b1;
                tbl_key[free_idx]    = p.delay_key;
                tbl_label[free_idx]  = p.task_label;
                tbl_target[free_idx] = target;
                r.status = ST_STARTED;
            end
        end
        else if (tbl_label[hit] != p.task_label) begin
            tbl_label[hit]  = p.task_label;
            tbl_target[hit] = target;
            r.status = ST_RESTARTED;
        end
        else if (p.now_ms >= tbl_target[hit]) begin
            // Plain unsigned compare: a target that wrapped past zero is due at once.
            tbl_valid[hit] = 1'b0;
            r.done_res = 1'b1;
            r.status   = ST_EXPIRED;
        end
        else begin
            r.status = ST_WAITING;
        end
        return r;
    endfunction

    function automatic poll_row_t mk_row(bit [31:0] key, bit [31:0] dly, bit [15:0] lbl,
                                         bit [31:0] now, bit intr, bit typed, bit done,
                                         status_t st);
        poll_row_t row;
        row.p.delay_key     = key;
        row.p.delay_ms      = dly;
        row.p.task_label    = lbl;
        row.p.now_ms        = now;
        row.p.in_interrupt  = intr;
        row.typed           = typed;
        row.want.done_res   = done;
        row.want.status     = st;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Presents one poll item and holds it until it is accepted. The expected
    // result is queued at acceptance, so the shadow table moves in step with
    // the block. A gap of zero keeps valid high for the next item.
    task automatic send_poll(poll_t p, bit typed, result_t typed_res, int gap);
        result_t r;
        poll       <= p;
        poll_valid <= 1'b1;
        do
            @(posedge clk);
        while (poll_stall);
        r = predict_poll(p);
        pending_results.push_back(typed ? typed_res : r);
        polls_sent++;
        if (gap > 0) begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        poll_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: drives its stall pattern and checks every accepted result item
    // against the oldest expectation, field by field.
    always @(posedge clk) begin : receiver
        result_t want;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end
        else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 1) == 1);
            default: result_stall <= ($urandom_range(0, 9) != 0);
        endcase

        if (rst_n && result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no poll outstanding", 32'(result.status), 32'd0);
            end
            else begin
                want = pending_results.pop_front();
                if (result.done_res !== want.done_res)
                    report_mismatch("done_res", 32'(result.done_res), 32'(want.done_res));
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (want.status <= ST_FULL)
                    status_seen[want.status]++;
            end
        end
    end

    // Watchdog: ends the run if no item moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((poll_valid && !poll_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        poll_row_t steps[$];
        poll_t     p;
        result_t   none;
        bit [31:0] pool_key   [POOL_SIZE];
        bit [15:0] pool_label [POOL_SIZE];
        bit [31:0] sim_now;
        int        burst_left;
        int        gap;
        int        pick;
        int        kind;

        none = '0;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;

        // Directed table. Bypass by interrupt with every other field at its top value
        // and the label at its most negative, bypass by a zero delay, then one key through
        // start, wait, restart on a label change and expiry exactly at the target.
        steps.push_back(mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 32'hFFFF_FFFF, 1'b1,
                               1'b1, 1'b1, ST_BYPASS));
        steps.push_back(mk_row(32'h0, 32'h0, 16'h7FFF, 32'h0, 1'b0, 1'b1, 1'b1, ST_BYPASS));
        steps.push_back(mk_row(32'hFFFF_FFFF, 32'd100, 16'h7FFF, 32'd0, 1'b0,
                               1'b1, 1'b0, ST_STARTED));
        steps.push_back(mk_row(32'hFFFF_FFFF, 32'd100, 16'h7FFF, 32'd50, 1'b0,
                               1'b0, 1'b0, ST_BYPASS));
        steps.push_back(mk_row(32'hFFFF_FFFF, 32'd10, 16'h8000, 32'd60, 1'b0,
                               1'b0, 1'b0, ST_BYPASS));
        steps.push_back(mk_row(32'hFFFF_FFFF, 32'd5, 16'h8000, 32'd70, 1'b0,
                               1'b0, 1'b0, ST_BYPASS));
        // A target that wraps past zero is reached on the very next poll.
        steps.push_back(mk_row(32'h0, 32'hFFFF_FFFF, 16'h0, 32'd1, 1'b0, 1'b0, 1'b0, ST_BYPASS));
        steps.push_back(mk_row(32'h0, 32'd1, 16'h0, 32'd2, 1'b0, 1'b0, 1'b0, ST_BYPASS));
        // Fill every slot, then one more new key must find the table full.
        for (int i = 0; i < SLOTS; i++) begin
            pool_key[i]   = 32'h1000_0000 + i;
            pool_label[i] = 16'(16'h1111 * i);
            steps.push_back(mk_row(pool_key[i], 32'd1000, pool_label[i], 32'd100, 1'b0,
                                   1'b0, 1'b0, ST_BYPASS));
        end
        steps.push_back(mk_row(32'h5A5A_A5A5, 32'd1, 16'h0, 32'd200, 1'b0,
                               1'b1, 1'b0, ST_FULL));

        for (int i = SLOTS; i < POOL_SIZE; i++) begin
            pool_key[i]   = $urandom;
            pool_label[i] = 16'($urandom);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            send_poll(steps[i].p, steps[i].typed, steps[i].want, $urandom_range(0, 3));
        drain_results();

        // Random part. Most items follow one of the pool keys through its life
        // on an advancing clock; the rest are bypasses, noise with random keys
        // and times, and polls that retire a live slot at or just past its target.
        sim_now    = 32'd300;
        burst_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // Pause until everything is back, then move the clock close to the wrap.
                drain_results();
                sim_now = 32'hFFFF_F000;
            end

            p.delay_key    = $urandom;
            p.delay_ms     = $urandom;
            p.task_label   = 16'($urandom);
            p.now_ms       = $urandom;
            p.in_interrupt = 1'b0;
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, SLOTS - 1);

            if (kind < 5) begin
                p.in_interrupt = 1'b1;
            end
            else if (kind < 8) begin
                p.delay_ms = 32'd0;
            end
            else if (kind < 12) begin
                // Noise: every field random except the interrupt flag.
            end
            else if (kind < 20 && tbl_valid[pick]) begin
                p.delay_key  = tbl_key[pick];
                p.task_label = tbl_label[pick];
                p.delay_ms   = $urandom_range(1, 500);
                p.now_ms     = (tbl_target[pick] > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF
                               : tbl_target[pick] + $urandom_range(0, 3);
            end
            else begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 9) == 0)
                    pool_label[pick] = 16'($urandom);
                p.delay_key  = pool_key[pick];
                p.task_label = pool_label[pick];
                p.delay_ms   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300);
                p.now_ms     = sim_now;
                sim_now      = sim_now + $urandom_range(0, 8);
            end

            // Sender bursts: back-to-back items, then a random gap.
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap        = $urandom_range(1, 25);
            end
            else begin
                burst_left--;
                gap = 0;
            end
            send_poll(p, 1'b0, none, gap);
        end

        drain_results();
        repeat (40) @(posedge clk);

        $display("Sent %0d polls, including table fill, label restarts and a clock wrap.",
                 polls_sent);
        $display({"Results: %0d bypass, %0d started, %0d restarted, ",
                  "%0d waiting, %0d expired, %0d full"},
                 status_seen[ST_BYPASS], status_seen[ST_STARTED], status_seen[ST_RESTARTED],
                 status_seen[ST_WAITING], status_seen[ST_EXPIRED], status_seen[ST_FULL]);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
